### sv/pli_pkg.sv
// Shared types, widths and the divider step of the piecewise linear interpolator.
package pli_pkg;

	localparam int NUM_REGS = 8;
	localparam int IDX_W = 3;
	localparam int REG_W = 24;
	localparam int X_W = 8;
	localparam int Y_W = 16;
	localparam int DY_W = Y_W + 1;
	localparam int PROD_W = DY_W + X_W + 1;
	localparam int NUM_W = 27;
	localparam int DEN_W = X_W + 1;
	localparam int QUO_W = 18;
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_W / STEPS_PER_STAGE;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] points_t;

	typedef struct packed {
		logic signed [Y_W-1:0]  y1;
		logic signed [DY_W-1:0] dy;
		logic [X_W-1:0]         u;
		logic [X_W-1:0]         d;
	} seg_t;

	typedef struct packed {
		logic signed [Y_W-1:0] y1;
		logic [DEN_W-1:0]      den;
		logic [DEN_W-1:0]      rem;
		logic [QUO_W-1:0]      dvd;
		logic [QUO_W-1:0]      quo;
	} div_t;

	function automatic div_t div_step(input div_t a);
		div_t r;
		logic [DEN_W:0] trial;
		r = a;
		trial = {a.rem, a.dvd[QUO_W-1]};
		if (trial >= {1'b0, a.den}) begin
			r.rem = DEN_W'(trial - {1'b0, a.den});
			r.quo = {a.quo[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = trial[DEN_W-1:0];
			r.quo = {a.quo[QUO_W-2:0], 1'b0};
		end
		r.dvd = {a.dvd[QUO_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

### sv/pli_select.sv
// Stage 1: segment search over the breakpoints and difference terms.
module pli_select #(
	parameter int POINTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pli_pkg::points_t       points,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [7:0]      temperature,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pli_pkg::seg_t          out_seg
);

	logic                    valid_s1;
	pli_pkg::seg_t           seg_s1;
	pli_pkg::seg_t           seg;
	logic [pli_pkg::IDX_W-1:0] hi;
	logic [pli_pkg::IDX_W-1:0] lo;
	logic signed [7:0]       x_last;
	logic signed [7:0]       x_first;
	logic signed [7:0]       x1;
	logic signed [7:0]       x2;
	logic signed [15:0]      y1;
	logic signed [15:0]      y2;
	logic [8:0]              d9;
	logic [8:0]              u9;

	always_comb begin
		x_last  = points[POINTS-1][23:16];
		x_first = points[0][23:16];
		hi = pli_pkg::IDX_W'(POINTS - 1);
		for (int k = POINTS - 1; k >= 1; k--) begin
			if ($signed(points[k][23:16]) >= temperature) begin
				hi = pli_pkg::IDX_W'(k);
			end
		end
		lo = hi - pli_pkg::IDX_W'(1);
		x1 = points[lo][23:16];
		y1 = points[lo][15:0];
		x2 = points[hi][23:16];
		y2 = points[hi][15:0];
		d9 = {x2[7], x2} - {x1[7], x1};
		u9 = {temperature[7], temperature} - {x1[7], x1};
		if (temperature >= x_last) begin
			seg.y1 = points[POINTS-1][15:0];
			seg.dy = '0;
			seg.u  = '0;
			seg.d  = 8'd1;
		end else if (temperature <= x_first) begin
			seg.y1 = points[0][15:0];
			seg.dy = '0;
			seg.u  = '0;
			seg.d  = 8'd1;
		end else begin
			seg.y1 = y1;
			seg.dy = {y2[15], y2} - {y1[15], y1};
			seg.u  = u9[7:0];
			seg.d  = d9[7:0];
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			seg_s1 <= seg;
		end
	end

	assign out_valid = valid_s1;
	assign out_seg   = seg_s1;

endmodule

### sv/pli_mul.sv
// Stage 2: slope product and biased dividend for the rounding divide.
module pli_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pli_pkg::seg_t in_seg,
	output logic          out_valid,
	input  logic          out_ready,
	output pli_pkg::div_t out_div
);

	logic                                valid_s2;
	pli_pkg::div_t                       div_s2;
	pli_pkg::div_t                       div_d;
	logic signed [pli_pkg::PROD_W-1:0]   prod;
	logic [pli_pkg::NUM_W-1:0]           num;

	assign prod = in_seg.dy * $signed({1'b0, in_seg.u});

	always_comb begin
		num = {prod, 1'b0} + pli_pkg::NUM_W'(in_seg.d)
			+ (pli_pkg::NUM_W'(in_seg.d) << pli_pkg::QUO_W);
		div_d.y1  = in_seg.y1;
		div_d.den = {in_seg.d, 1'b0};
		div_d.rem = num[pli_pkg::NUM_W-1:pli_pkg::QUO_W];
		div_d.dvd = num[pli_pkg::QUO_W-1:0];
		div_d.quo = '0;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_s2 <= div_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_div   = div_s2;

endmodule

### sv/pli_divider.sv
// Stages 3 to 11: pipelined restoring divider, two quotient bits per stage.
module pli_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pli_pkg::div_t in_div,
	output logic          out_valid,
	input  logic          out_ready,
	output pli_pkg::div_t out_div
);

	localparam int N = pli_pkg::DIV_STAGES;

	logic [N-1:0]  valid_sn;
	logic [N-1:0]  ready_sn;
	logic [N:1]    next_ready;
	pli_pkg::div_t data_sn [N];
	pli_pkg::div_t step_in [N];
	pli_pkg::div_t step_out [N];

	assign next_ready[N] = out_ready;
	assign in_ready = ready_sn[0];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic stage_in_valid;
		if (i == 0) begin : g_first
			assign step_in[i]     = in_div;
			assign stage_in_valid = in_valid;
		end else begin : g_rest
			assign step_in[i]     = data_sn[i-1];
			assign stage_in_valid = valid_sn[i-1];
			assign next_ready[i]  = ready_sn[i];
		end

		always_comb begin
			step_out[i] = step_in[i];
			for (int s = 0; s < pli_pkg::STEPS_PER_STAGE; s++) begin
				step_out[i] = pli_pkg::div_step(step_out[i]);
			end
		end

		assign ready_sn[i] = !valid_sn[i] || next_ready[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[i] <= 1'b0;
			end else if (ready_sn[i]) begin
				valid_sn[i] <= stage_in_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (ready_sn[i] && stage_in_valid) begin
				data_sn[i] <= step_out[i];
			end
		end
	end

	assign out_valid = valid_sn[N-1];
	assign out_div   = data_sn[N-1];

endmodule

### sv/piecewise_linear_interpolator_core.sv
// Top level of the piecewise linear interpolator: breakpoint registers and output stage.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes breakpoint
//   register cfg_index; cfg_ready is always high. Bits 23:16 of a register hold
//   the signed x, bits 15:0 the signed y. Registers at or above POINTS are kept
//   but unused. Write them only while no item is in flight.
//   Input channel (in_valid/in_ready, temperature) takes one signed temperature
//   per transfer; output channel (out_valid/out_ready, curve_value) returns the
//   rounded curve value, one result per input, in order.
//   The pipeline has 12 register stages: segment search, slope multiply, nine
//   stages of a two-bit-per-stage restoring divider, and the final add, whose
//   register drives out_valid and curve_value. It takes one item per cycle
//   whenever in_ready is high.
//   Reset clears all breakpoint registers to zero and empties the pipeline.
//   When out_ready is low the pipeline keeps filling empty stages and drops
//   in_ready only once every stage holds an item; nothing is lost or repeated.
module piecewise_linear_interpolator_core #(
	parameter int POINTS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pli_pkg::IDX_W-1:0]           cfg_index,
	input  logic [pli_pkg::REG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pli_pkg::X_W-1:0]      temperature,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pli_pkg::Y_W-1:0]      curve_value
);

	pli_pkg::points_t points_q;
	pli_pkg::seg_t    seg;
	pli_pkg::div_t    mul_div;
	pli_pkg::div_t    div_res;
	logic             sel_valid;
	logic             sel_ready;
	logic             mul_valid;
	logic             mul_ready;
	logic             div_valid;
	logic             div_ready;
	logic             valid_s12;
	logic signed [pli_pkg::Y_W-1:0] value_s12;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			points_q[cfg_index] <= cfg_data;
		end
	end

	pli_select #(
		.POINTS(POINTS)
	) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.points     (points_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.temperature(temperature),
		.out_valid  (sel_valid),
		.out_ready  (sel_ready),
		.out_seg    (seg)
	);

	pli_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sel_valid),
		.in_ready (sel_ready),
		.in_seg   (seg),
		.out_valid(mul_valid),
		.out_ready(mul_ready),
		.out_div  (mul_div)
	);

	pli_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mul_valid),
		.in_ready (mul_ready),
		.in_div   (mul_div),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.out_div  (div_res)
	);

	// quotient carries a bias of 2^17, which vanishes in the low 16 bits
	assign div_ready = !valid_s12 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (div_ready) begin
			valid_s12 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ready && div_valid) begin
			value_s12 <= div_res.y1 + $signed(div_res.quo[pli_pkg::Y_W-1:0]);
		end
	end

	assign out_valid   = valid_s12;
	assign curve_value = value_s12;

endmodule
